// ----- design/rad_pkg.sv -----
// Shared types, sizes and codes for the region address decoder.
package rad_pkg;

    // Table and address sizing
    localparam int MAX_REGIONS = 16;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // Fixed field widths of the ports
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int ST_W      = 3;
    localparam int OUT_IDX_W = 4;
    localparam int SIZE_W    = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Region kinds
    localparam logic [KIND_W-1:0] KIND_RAM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEV = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NOREGION = 3'd1;
    localparam logic [ST_W-1:0] ST_SIZE     = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD      = 3'd4;

    // Direction masks, bit0 read and bit1 write
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_RD   = 2'b01;
    localparam logic [1:0] DIR_WR   = 2'b10;

    localparam logic [SIZE_W-1:0] SIZE_ALL = 4'b1111;

    typedef struct packed {
        logic              direct;
        logic [SIZE_W-1:0] size;
        logic              wr;
        logic              rd;
    } region_flags_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] mask;
        region_flags_t     flags;
    } region_entry_t;

    // Access under lookup, broadcast to every cell
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        dir;
        logic [SIZE_W-1:0] sbit;
    } probe_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              live;
        logic              found;
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] target;
        logic              dev;
    } tok_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [OUT_IDX_W-1:0] index;
        logic [ADDR_W-1:0]    target;
        logic                 dev;
    } result_t;

endpackage

// ----- design/rad_cell.sv -----
// One table entry of the decoder chain with its stage of the search token.
module rad_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rad_pkg::IDX_W-1:0]   cell_idx,
    input  logic [rad_pkg::CNT_W-1:0]   count,
    input  logic                        wr_en,
    input  logic [rad_pkg::IDX_W-1:0]   wr_slot,
    input  rad_pkg::region_entry_t      wr_region,
    input  rad_pkg::probe_t             probe,
    input  rad_pkg::tok_t               tok_in,
    output rad_pkg::tok_t               tok_out
);
    import rad_pkg::*;

    region_entry_t entry_reg;
    tok_t    tok_reg;
    tok_t    tok_next;
    logic    in_use;
    logic    in_range;
    logic    dir_ok;
    logic    size_ok;

    // Entry store, written once when its slot is appended
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_slot == cell_idx))
        begin
            entry_reg <= wr_region;
        end
    end

    // Match terms against the broadcast access
    assign in_use   = CNT_W'(cell_idx) < count;
    assign in_range = (probe.addr >= entry_reg.lo) && (probe.addr <= entry_reg.hi);
    assign dir_ok   = (probe.dir & {entry_reg.flags.wr, entry_reg.flags.rd}) != 2'b00;
    assign size_ok  = (probe.sbit & entry_reg.flags.size) != '0;

    // First hit claims the token; later cells pass it on untouched
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.live && !tok_in.found && in_use && in_range && dir_ok)
        begin
            tok_next.found = 1'b1;
            tok_next.index = cell_idx;
            if (size_ok)
            begin
                tok_next.status = ST_OK;
                tok_next.target = entry_reg.flags.direct ? (probe.addr & entry_reg.mask)
                                                         : probe.addr;
                tok_next.dev    = !entry_reg.flags.direct;
            end
            else
            begin
                tok_next.status = ST_SIZE;
                tok_next.target = '0;
                tok_next.dev    = 1'b0;
            end
        end
    end

    // Token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- design/region_address_decoder_unit.sv -----
// Top level of the region address decoder: add/access control and the cell chain.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+------------------------------------------------
//  request | req_valid | req_stall | op addr region_top region_mask region_kind
//          |           |           | rw_perm size_perm access_size
//  result  | rsp_valid | rsp_stall | status region_index target_addr to_device
//
// An add word is decided combinationally and its result registered at once.
// An access word sends a token down the chain of MAX_REGIONS cells, one cell a
// cycle; its result passes start_reg, the cell registers, fin_reg and rsp_reg,
// and the next word can be taken once the result has moved into rsp_reg.
// One word is in work at a time; req_stall is high during a lookup and while
// an unaccepted result blocks the output register.
// Reset empties the region table at once; entry contents are left as they are.
module region_address_decoder_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [rad_pkg::OP_W-1:0]       op,
    input  logic [rad_pkg::ADDR_W-1:0]     addr,
    input  logic [rad_pkg::ADDR_W-1:0]     region_top,
    input  logic [rad_pkg::ADDR_W-1:0]     region_mask,
    input  logic [rad_pkg::KIND_W-1:0]     region_kind,
    input  logic [1:0]                     rw_perm,
    input  logic [rad_pkg::SIZE_W-1:0]     size_perm,
    input  logic [1:0]                     access_size,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [rad_pkg::ST_W-1:0]       status,
    output logic [rad_pkg::OUT_IDX_W-1:0]  region_index,
    output logic [rad_pkg::ADDR_W-1:0]     target_addr,
    output logic                           to_device
);
    import rad_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic               start_reg;
    logic               busy_reg;
    probe_t             probe_reg;
    logic               fin_valid_reg;
    result_t            fin_reg;
    logic               rsp_valid_reg;
    result_t            rsp_reg;

    logic               take;
    logic               is_add;
    logic               rsp_free;
    logic               add_bad;
    logic               table_full;
    logic               add_ok;
    logic [IDX_W-1:0]   wr_slot;
    region_entry_t      new_region;
    result_t            add_res;
    result_t            sweep_res;
    probe_t             probe_next;
    tok_t               chain [MAX_REGIONS+1];
    tok_t               last_tok;
    logic [MAX_REGIONS-1:0] live_vec;

    // Handshake
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = busy_reg || !rsp_free;
    assign take      = req_valid && !req_stall;
    assign is_add    = op == OP_ADD;

    // Region check and flags for an add word
    always_comb
    begin
        add_bad          = (region_top <= addr) || (region_mask == '0);
        new_region.lo    = addr;
        new_region.hi    = region_top;
        new_region.mask  = region_mask;
        new_region.flags = '0;
        unique case (region_kind)
            KIND_RAM:
            begin
                new_region.flags = '{direct: 1'b1, size: SIZE_ALL, wr: 1'b1, rd: 1'b1};
            end
            KIND_ROM:
            begin
                new_region.flags = '{direct: 1'b1, size: SIZE_ALL, wr: 1'b0, rd: 1'b1};
                if (rw_perm[1])
                begin
                    add_bad = 1'b1;
                end
            end
            KIND_DEV:
            begin
                new_region.flags = '{direct: 1'b0, size: size_perm,
                                     wr: rw_perm[1], rd: rw_perm[0]};
                if ((rw_perm == 2'b00) || (size_perm == '0))
                begin
                    add_bad = 1'b1;
                end
            end
            default:
            begin
                add_bad = 1'b1;
            end
        endcase
    end

    assign table_full = count_reg == CNT_W'(MAX_REGIONS);
    assign add_ok     = take && is_add && !add_bad && !table_full;
    assign wr_slot    = count_reg[IDX_W-1:0];

    // Result word of an add
    always_comb
    begin
        add_res = '0;
        if (add_bad)
        begin
            add_res.status = ST_BAD;
        end
        else if (table_full)
        begin
            add_res.status = ST_FULL;
        end
        else
        begin
            add_res.status = ST_OK;
            add_res.index  = OUT_IDX_W'(wr_slot);
            add_res.dev    = region_kind == KIND_DEV;
        end
    end

    // Access decode: direction mask and one-hot size bit
    always_comb
    begin
        probe_next.addr = addr;
        probe_next.sbit = SIZE_W'(1) << access_size;
        unique case (op)
            OP_READ:  probe_next.dir = DIR_RD;
            OP_WRITE: probe_next.dir = DIR_WR;
            default:  probe_next.dir = DIR_NONE;
        endcase
    end

    // Cell chain
    always_comb
    begin
        chain[0]      = '0;
        chain[0].live = start_reg;
    end

    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        rad_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(i)),
            .count     (count_reg),
            .wr_en     (add_ok),
            .wr_slot   (wr_slot),
            .wr_region (new_region),
            .probe     (probe_reg),
            .tok_in    (chain[i]),
            .tok_out   (chain[i+1])
        );
        assign live_vec[i] = chain[i+1].live;
    end

    assign last_tok = chain[MAX_REGIONS];

    // Token leaving the chain becomes a result word
    always_comb
    begin
        sweep_res = '0;
        if (last_tok.found)
        begin
            sweep_res.status = last_tok.status;
            sweep_res.index  = OUT_IDX_W'(last_tok.index);
            sweep_res.target = last_tok.target;
            sweep_res.dev    = last_tok.dev;
        end
        else
        begin
            sweep_res.status = ST_NOREGION;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take && !is_add)
        begin
            probe_reg <= probe_next;
        end
        if (last_tok.live)
        begin
            fin_reg <= sweep_res;
        end
        if (take && is_add)
        begin
            rsp_reg <= add_res;
        end
        else if (fin_valid_reg && rsp_free)
        begin
            rsp_reg <= fin_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            start_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (add_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            start_reg <= take && !is_add;
            if (take && !is_add)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin_valid_reg && rsp_free)
            begin
                busy_reg <= 1'b0;
            end
            if (last_tok.live)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (rsp_free)
            begin
                fin_valid_reg <= 1'b0;
            end
            if ((take && is_add) || (fin_valid_reg && rsp_free))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_reg.status;
    assign region_index = rsp_reg.index;
    assign target_addr  = rsp_reg.target;
    assign to_device    = rsp_reg.dev;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count beyond table size");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({start_reg, live_vec, fin_valid_reg}) <= 1)
        else $error("more than one lookup in flight");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (!start_reg && (live_vec == '0) && !fin_valid_reg))
        else $error("lookup activity while not busy");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        add_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted add did not grow the table");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_FULL)) |-> table_full)
        else $error("table full reported with free slots");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the region address decoder: queued words, table predictor, monitor.
module tb;
    import rad_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int N_RANDOM     = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * (MAX_REGIONS + 3);
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 150;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] mask;
        logic [KIND_W-1:0] kind;
        logic [1:0]        rw;
        logic [SIZE_W-1:0] sizes;
        logic [1:0]        acc_size;
    } req_word_t;

    typedef enum logic [1:0] {SINK_FREE, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [ST_W-1:0]      status;
    logic [OUT_IDX_W-1:0] region_index;
    logic [ADDR_W-1:0]    target_addr;
    logic                 to_device;
    req_word_t cur_word = '0;
    logic req_taken = 1'b0;

    // Words waiting to be sent and decodes waiting to come back
    req_word_t pending_words[$];
    result_t   expected_results[$];

    // Bounds of regions the stimulus expects in the table, used to aim accesses
    logic [ADDR_W-1:0] hint_lo[$];
    logic [ADDR_W-1:0] hint_hi[$];

    // Predicted region table
    region_entry_t region_tab [MAX_REGIONS];
    int      region_used = 0;

    int fail_count  = 0;
    int cycle_count = 0;
    int words_taken = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int mode_left   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    sink_mode_t stall_mode = SINK_FREE;

    region_address_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .op           (cur_word.op),
        .addr         (cur_word.addr),
        .region_top   (cur_word.top),
        .region_mask  (cur_word.mask),
        .region_kind  (cur_word.kind),
        .rw_perm      (cur_word.rw),
        .size_perm    (cur_word.sizes),
        .access_size  (cur_word.acc_size),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .region_index (region_index),
        .target_addr  (target_addr),
        .to_device    (to_device)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decode one accepted word against the predicted table, updating it on an add
    function automatic result_t decode_word(input req_word_t w);
        result_t       res;
        region_flags_t fl;
        logic          bad;
        logic [1:0]    dir;
        int            hit;
        res = '0;
        fl  = '0;
        hit = -1;
        if (w.op == OP_ADD)
        begin
            bad = (w.top <= w.addr) || (w.mask == '0);
            case (w.kind)
                KIND_RAM: fl = '{direct: 1'b1, size: SIZE_ALL, wr: 1'b1, rd: 1'b1};
                KIND_ROM:
                begin
                    if (w.rw[1])
                        bad = 1'b1;
                    fl = '{direct: 1'b1, size: SIZE_ALL, wr: 1'b0, rd: 1'b1};
                end
                KIND_DEV:
                begin
                    if (w.rw == 2'b00 || w.sizes == '0)
                        bad = 1'b1;
                    fl = '{direct: 1'b0, size: w.sizes, wr: w.rw[1], rd: w.rw[0]};
                end
                default: bad = 1'b1;
            endcase
            if (bad)
                res.status = ST_BAD;
            else if (region_used >= MAX_REGIONS)
                res.status = ST_FULL;
            else
            begin
                region_tab[region_used] = '{lo: w.addr, hi: w.top, mask: w.mask, flags: fl};
                res.status = ST_OK;
                res.index  = OUT_IDX_W'(region_used);
                res.dev    = (w.kind == KIND_DEV);
                region_used++;
            end
        end
        else
        begin
            dir = (w.op == OP_READ) ? DIR_RD : (w.op == OP_WRITE) ? DIR_WR : DIR_NONE;
            // first region in order of addition that holds the address and grants the direction
            for (int i = 0; i < region_used; i++)
                if (hit < 0 && w.addr >= region_tab[i].lo && w.addr <= region_tab[i].hi &&
                    (dir & {region_tab[i].flags.wr, region_tab[i].flags.rd}) != 2'b00)
                    hit = i;
            if (hit < 0)
                res.status = ST_NOREGION;
            else if (!region_tab[hit].flags.size[w.acc_size])
            begin
                res.status = ST_SIZE;
                res.index  = OUT_IDX_W'(hit);
            end
            else
            begin
                res.status = ST_OK;
                res.index  = OUT_IDX_W'(hit);
                if (region_tab[hit].flags.direct)
                    res.target = w.addr & region_tab[hit].mask;
                else
                begin
                    res.target = w.addr;
                    res.dev    = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic req_word_t make_access(input logic [OP_W-1:0] a_op,
                                              input logic [ADDR_W-1:0] a,
                                              input logic [1:0] sz);
        req_word_t w;
        w.op       = a_op;
        w.addr     = a;
        w.top      = $urandom;
        w.mask     = $urandom;
        w.kind     = KIND_W'($urandom);
        w.rw       = 2'($urandom);
        w.sizes    = SIZE_W'($urandom);
        w.acc_size = sz;
        return w;
    endfunction

    // Queue an add word; a region meant to land in the table is remembered for aiming
    task automatic queue_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                                input logic [ADDR_W-1:0] msk, input logic [KIND_W-1:0] kd,
                                input logic [1:0] rw, input logic [SIZE_W-1:0] sz,
                                input bit keep_hint);
        req_word_t w;
        w = '{op: OP_ADD, addr: lo, top: hi, mask: msk, kind: kd, rw: rw, sizes: sz,
              acc_size: 2'($urandom)};
        pending_words.push_back(w);
        if (keep_hint && hint_lo.size() < MAX_REGIONS)
        begin
            hint_lo.push_back(lo);
            hint_hi.push_back(hi);
        end
    endtask

    // Address near or inside a known region, or anywhere
    function automatic logic [ADDR_W-1:0] pick_addr();
        int              idx;
        longint unsigned span;
        longint unsigned off;
        if (hint_lo.size() == 0 || $urandom_range(0, 3) == 0)
            return $urandom;
        idx  = $urandom_range(0, hint_lo.size() - 1);
        span = longint'(hint_hi[idx]) - longint'(hint_lo[idx]) + 1;
        off  = longint'($urandom) % span;
        case ($urandom_range(0, 5))
            0: return hint_lo[idx];
            1: return hint_hi[idx];
            2: return hint_lo[idx] - 1;
            3: return hint_hi[idx] + 1;
            default: return hint_lo[idx] + off[ADDR_W-1:0];
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    // Monitor, acceptance and timeout, all on the rising edge
    always @(posedge clk)
    begin : watch
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result word with none outstanding", target_addr, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (region_index !== want.index)
                        report_mismatch("region_index", 32'(region_index), 32'(want.index));
                    if (target_addr !== want.target)
                        report_mismatch("target_addr", target_addr, want.target);
                    if (to_device !== want.dev)
                        report_mismatch("to_device", 32'(to_device), 32'(want.dev));
                end
            end
            if (rst_n && req_valid && !req_stall)
            begin
                expected_results.push_back(decode_word(cur_word));
                words_taken++;
                req_taken <= 1'b1;
            end
            else
                req_taken <= 1'b0;
        end
    end

    // Sender: bursts of words with random gaps, payload held until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (gap_left > 0 || pending_words.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                req_valid <= 1'b0;
            end
            else
            begin
                cur_word  <= pending_words.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: stall pattern changing mode now and then, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (!hold_done && words_taken >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                stall_mode = sink_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    SINK_FREE:  rsp_stall <= 1'b0;
                    SINK_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                    default:    rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int r;
        int k;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] msk;
        logic [KIND_W-1:0] kd;
        logic [1:0]        rw;
        logic [SIZE_W-1:0] sz;

        // accesses against an empty table, including the unused op
        pending_words.push_back(make_access(OP_READ, 32'h0000_0000, 2'd0));
        pending_words.push_back(make_access(OP_WRITE, 32'hFFFF_FFFF, 2'd3));
        pending_words.push_back(make_access(OP_SPARE, 32'h0000_1234, 2'd2));
        // each way of giving a bad region
        queue_region(32'h100, 32'h100, 32'hFF, KIND_RAM, 2'd0, 4'd0, 1'b0);
        queue_region(32'hFFFF_FFFF, 32'h0, 32'hFF, KIND_RAM, 2'd3, 4'hF, 1'b0);
        queue_region(32'h0, 32'hFFFF_FFFF, 32'h0, KIND_RAM, 2'd3, 4'hF, 1'b0);
        queue_region(32'h0, 32'hFF, 32'hFF, KIND_SPARE, 2'd3, 4'hF, 1'b0);
        queue_region(32'h0, 32'hFF, 32'hFF, KIND_ROM, 2'd2, 4'hF, 1'b0);
        queue_region(32'h0, 32'hFF, 32'hFF, KIND_DEV, 2'd0, 4'hF, 1'b0);
        queue_region(32'h0, 32'hFF, 32'hFF, KIND_DEV, 2'd3, 4'h0, 1'b0);
        // one of each kind, then accesses aimed at them
        queue_region(32'h1000, 32'h1FFF, 32'h0FFF, KIND_RAM, 2'd0, 4'd0, 1'b1);
        queue_region(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_ROM, 2'd1, 4'd0, 1'b1);
        queue_region(32'h8000_0000, 32'h8000_00FF, 32'h1, KIND_DEV, DIR_WR, 4'b0100, 1'b1);
        pending_words.push_back(make_access(OP_READ, 32'h0000_1000, 2'd3));
        pending_words.push_back(make_access(OP_WRITE, 32'h0000_1FFF, 2'd0));
        pending_words.push_back(make_access(OP_READ, 32'h0000_2000, 2'd1));
        pending_words.push_back(make_access(OP_WRITE, 32'h0000_2000, 2'd1));
        pending_words.push_back(make_access(OP_WRITE, 32'h8000_0080, 2'd2));
        pending_words.push_back(make_access(OP_WRITE, 32'h8000_0080, 2'd1));
        pending_words.push_back(make_access(OP_READ, 32'h8000_0080, 2'd2));
        pending_words.push_back(make_access(OP_WRITE, 32'h8000_0100, 2'd2));
        pending_words.push_back(make_access(OP_SPARE, 32'h0000_1800, 2'd0));
        queue_region(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_DEV, 2'd3, 4'b1000, 1'b1);
        pending_words.push_back(make_access(OP_READ, 32'hFFFF_FFFF, 2'd3));
        pending_words.push_back(make_access(OP_WRITE, 32'hFFFF_FFFF, 2'd3));

        // random words: mostly aimed accesses, some adds, some noise
        for (int n = 0; n < N_RANDOM; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                pending_words.push_back(make_access(OP_W'($urandom), $urandom, 2'($urandom)));
            else if (r < 8 + ((hint_lo.size() < MAX_REGIONS) ? 7 : 3))
            begin
                // well-formed region first, then maybe break one thing about it
                if (hint_lo.size() > 0 && $urandom_range(0, 1) == 1)
                    lo = hint_lo[$urandom_range(0, hint_lo.size() - 1)] + $urandom_range(0, 64);
                else
                    lo = $urandom;
                case ($urandom_range(0, 3))
                    0:       span = $urandom_range(1, 255);
                    1, 2:    span = $urandom_range(1, 65535);
                    default: span = $urandom | 32'h1;
                endcase
                if (lo > 32'hFFFF_FFFF - span)
                    lo = 32'hFFFF_FFFF - span;
                hi = lo + span;
                case ($urandom_range(0, 2))
                    0:       msk = '1;
                    1:       msk = 32'hFFFF_FFFF >> $urandom_range(0, 31);
                    default: msk = $urandom | 32'h1;
                endcase
                kd = KIND_W'($urandom_range(0, 2));
                rw = (kd == KIND_ROM) ? 2'($urandom_range(0, 1)) :
                     (kd == KIND_DEV) ? 2'($urandom_range(1, 3)) : 2'($urandom);
                sz = (kd == KIND_DEV) ? SIZE_W'($urandom_range(1, 15)) : SIZE_W'($urandom);
                if ($urandom_range(0, 3) != 0)
                    queue_region(lo, hi, msk, kd, rw, sz, 1'b1);
                else
                begin
                    case ($urandom_range(0, 6))
                        0: hi = lo >> $urandom_range(0, 4);
                        1: hi = lo;
                        2: msk = '0;
                        3: kd = KIND_SPARE;
                        4:
                        begin
                            kd = KIND_ROM;
                            rw = 2'($urandom_range(2, 3));
                        end
                        5:
                        begin
                            kd = KIND_DEV;
                            rw = 2'b00;
                        end
                        default:
                        begin
                            kd = KIND_DEV;
                            sz = '0;
                        end
                    endcase
                    queue_region(lo, hi, msk, kd, rw, sz, 1'b0);
                end
            end
            else
            begin
                k = $urandom_range(0, 49);
                pending_words.push_back(make_access((k == 0) ? OP_SPARE :
                                                    (k % 2 == 1) ? OP_READ : OP_WRITE,
                                                    pick_addr(), 2'($urandom)));
            end
        end

        // reset once, released away from the rising edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
